>>> hw/rtl/chacha20_keystream_xor_unit_assert.svh
// Assertion macros for the keystream XOR unit.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef CHACHA20_KEYSTREAM_XOR_UNIT_ASSERT_SVH
`define CHACHA20_KEYSTREAM_XOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CCXOR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CCXOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CCXOR_ASSERT_SAME(lbl, ante, cons, msg)
`define CCXOR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/ccxor_pkg.sv
package ccxor_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned BLK_WORDS   = 16;
  localparam int unsigned KEY_WORDS   = 8;
  localparam int unsigned ROUNDS      = 20;
  localparam int unsigned ROUND_W     = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [WORD_W-1:0] SIGMA0      = 32'h61707865;
  localparam logic [WORD_W-1:0] SIGMA1      = 32'h3320646e;
  localparam logic [WORD_W-1:0] SIGMA2      = 32'h79622d32;
  localparam logic [WORD_W-1:0] SIGMA3      = 32'h6b206574;
  localparam logic [WORD_W-1:0] SWAP_MID_HI = 32'h00ff0000;
  localparam logic [WORD_W-1:0] SWAP_MID_LO = 32'h0000ff00;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_45 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_67 = 3'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [BLK_WORDS-1:0] blk_t;
  typedef word_t [KEY_WORDS-1:0] key_t;
  typedef word_t [3:0] quad_t;

  typedef struct packed {
    word_t            data;
    logic [CNT_W-1:0] cnt;
    logic             last;
    logic [POS_W-1:0] pos;
    logic             new_blk;
  } q_entry_t;

  typedef struct packed {
    logic  start;
    word_t ctr;
    word_t nonce;
  } gen_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } gen_stat_t;

  function automatic word_t rotl(input word_t v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic word_t swap_bytes(input word_t v);
    return (v >> 24) | (v << 24) | ((v << 8) & SWAP_MID_HI) | ((v >> 8) & SWAP_MID_LO);
  endfunction

  function automatic word_t byte_mask(input logic [CNT_W-1:0] cnt);
    word_t m;
    case (cnt)
      3'd0:    m = 32'h00000000;
      3'd1:    m = 32'h000000ff;
      3'd2:    m = 32'h0000ffff;
      3'd3:    m = 32'h00ffffff;
      default: m = 32'hffffffff;
    endcase
    return m;
  endfunction

  function automatic blk_t init_block(input key_t key, input word_t ctr, input word_t nonce);
    blk_t b;
    b[0] = SIGMA0;
    b[1] = SIGMA1;
    b[2] = SIGMA2;
    b[3] = SIGMA3;
    for (int i = 0; i < KEY_WORDS; i++) begin
      b[4 + i] = key[i];
    end
    b[12] = ctr;
    b[13] = '0;
    b[14] = '0;
    b[15] = nonce;
    return b;
  endfunction

  function automatic quad_t quarter(input word_t a_i, input word_t b_i,
                                    input word_t c_i, input word_t d_i);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    quad_t q;
    a = a_i;
    b = b_i;
    c = c_i;
    d = d_i;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    q[0] = a;
    q[1] = b;
    q[2] = c;
    q[3] = d;
    return q;
  endfunction

  // One round: four independent quarter rounds over columns or diagonals.
  function automatic blk_t one_round(input blk_t w, input logic diag);
    blk_t  r;
    quad_t q;
    int    bi;
    int    ci;
    int    di;
    r = w;
    for (int i = 0; i < 4; i++) begin
      bi = diag ? 4 + ((i + 1) & 3)  : 4 + i;
      ci = diag ? 8 + ((i + 2) & 3)  : 8 + i;
      di = diag ? 12 + ((i + 3) & 3) : 12 + i;
      q = quarter(w[i], w[bi], w[ci], w[di]);
      r[i]  = q[0];
      r[bi] = q[1];
      r[ci] = q[2];
      r[di] = q[3];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ccxor_front.sv
module ccxor_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_msg_start,
  input  ccxor_pkg::word_t            in_seq_number,
  input  ccxor_pkg::word_t            in_start_block,
  input  ccxor_pkg::word_t            in_data_in,
  input  logic [ccxor_pkg::CNT_W-1:0] in_byte_count,
  input  logic                        in_msg_last,
  input  logic                        q_full_i,
  input  ccxor_pkg::gen_stat_t        gen_stat_i,
  output logic                        push_o,
  output ccxor_pkg::q_entry_t         entry_o,
  output ccxor_pkg::gen_req_t         req_o
);

  logic [ccxor_pkg::POS_W-1:0] pos_r, pos_nxt;
  ccxor_pkg::word_t            ctr_r, ctr_nxt;
  ccxor_pkg::word_t            nonce_r, nonce_nxt;
  logic [ccxor_pkg::POS_W-1:0] eff_pos;
  ccxor_pkg::word_t            eff_ctr;
  ccxor_pkg::word_t            eff_nonce;
  logic                        need_blk;

  // A message start restarts the stream; a block is needed at position zero.
  always_comb begin
    eff_pos   = in_msg_start ? '0 : pos_r;
    eff_ctr   = in_msg_start ? in_start_block : ctr_r;
    eff_nonce = in_msg_start ? ccxor_pkg::swap_bytes(in_seq_number) : nonce_r;
    need_blk  = (eff_pos == '0);
    in_ready  = !q_full_i && (!need_blk || gen_stat_i.idle);
    push_o    = in_valid && in_ready;

    req_o.start = push_o && need_blk;
    req_o.ctr   = eff_ctr;
    req_o.nonce = eff_nonce;

    entry_o.data    = in_data_in;
    entry_o.cnt     = in_byte_count;
    entry_o.last    = in_msg_last;
    entry_o.pos     = eff_pos;
    entry_o.new_blk = need_blk;

    pos_nxt   = pos_r;
    ctr_nxt   = ctr_r;
    nonce_nxt = nonce_r;
    if (push_o) begin
      pos_nxt   = eff_pos + 1'b1;
      ctr_nxt   = need_blk ? eff_ctr + 1'b1 : eff_ctr;
      nonce_nxt = eff_nonce;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ctr_r   <= '0;
      nonce_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      ctr_r   <= ctr_nxt;
      nonce_r <= nonce_nxt;
    end
  end

endmodule

>>> hw/rtl/ccxor_fifo.sv
module ccxor_fifo #(
  parameter int unsigned DEPTH = ccxor_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  ccxor_pkg::q_entry_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output ccxor_pkg::q_entry_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ccxor_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    full_o  = (cnt_r == CNT_W'(DEPTH));
    valid_o = (cnt_r != '0);
    head_o  = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
  end

endmodule

>>> hw/rtl/ccxor_core.sv
module ccxor_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccxor_pkg::key_t      key_i,
  input  ccxor_pkg::gen_req_t  req_i,
  input  logic                 take_i,
  output ccxor_pkg::gen_stat_t stat_o,
  output ccxor_pkg::blk_t      sum_o
);

  localparam logic [1:0] GEN_IDLE = 2'd0;
  localparam logic [1:0] GEN_RUN  = 2'd1;
  localparam logic [1:0] GEN_DONE = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [ccxor_pkg::ROUND_W-1:0] round_r, round_nxt;
  ccxor_pkg::blk_t               w_r, w_nxt;
  ccxor_pkg::word_t              ctr_r, ctr_nxt;
  ccxor_pkg::word_t              nonce_r, nonce_nxt;
  ccxor_pkg::blk_t               init_run;

  always_comb begin
    init_run = ccxor_pkg::init_block(key_i, ctr_r, nonce_r);
    for (int i = 0; i < ccxor_pkg::BLK_WORDS; i++) begin
      sum_o[i] = w_r[i] + init_run[i];
    end
    stat_o.idle = (state_r == GEN_IDLE);
    stat_o.done = (state_r == GEN_DONE);

    state_nxt = state_r;
    round_nxt = round_r;
    w_nxt     = w_r;
    ctr_nxt   = ctr_r;
    nonce_nxt = nonce_r;
    case (state_r)
      GEN_IDLE: begin
        if (req_i.start) begin
          state_nxt = GEN_RUN;
          round_nxt = '0;
          ctr_nxt   = req_i.ctr;
          nonce_nxt = req_i.nonce;
          w_nxt     = ccxor_pkg::init_block(key_i, req_i.ctr, req_i.nonce);
        end
      end
      GEN_RUN: begin
        // Even rounds work on columns, odd rounds on diagonals.
        w_nxt     = ccxor_pkg::one_round(w_r, round_r[0]);
        round_nxt = round_r + 1'b1;
        if (round_r == ccxor_pkg::ROUND_W'(ccxor_pkg::ROUNDS - 1)) begin
          state_nxt = GEN_DONE;
        end
      end
      GEN_DONE: begin
        if (take_i) begin
          state_nxt = GEN_IDLE;
        end
      end
      default: begin
        state_nxt = GEN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GEN_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    ctr_r   <= ctr_nxt;
    nonce_r <= nonce_nxt;
  end

endmodule

>>> hw/rtl/ccxor_back.sv
module ccxor_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid_i,
  input  ccxor_pkg::q_entry_t         head_i,
  output logic                        pop_o,
  input  ccxor_pkg::gen_stat_t        gen_stat_i,
  input  ccxor_pkg::blk_t             gen_sum_i,
  output logic                        take_o,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ccxor_pkg::word_t            out_data_out,
  output logic [ccxor_pkg::CNT_W-1:0] out_byte_count,
  output logic                        out_last
);

  ccxor_pkg::blk_t             ks_r, ks_nxt;
  logic                        valid_r, valid_nxt;
  ccxor_pkg::word_t            data_r, data_nxt;
  logic [ccxor_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        last_r, last_nxt;
  ccxor_pkg::word_t            ks_word;

  always_comb begin
    // A request that opens a block waits for the generator to finish it.
    pop_o  = q_valid_i && (!valid_r || out_ready) && (!head_i.new_blk || gen_stat_i.done);
    take_o = pop_o && head_i.new_blk;
    ks_word = head_i.new_blk ? gen_sum_i[0] : ks_r[head_i.pos];

    ks_nxt    = take_o ? gen_sum_i : ks_r;
    valid_nxt = pop_o || (valid_r && !out_ready);
    data_nxt  = data_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    if (pop_o) begin
      data_nxt = (head_i.data ^ ks_word) & ccxor_pkg::byte_mask(head_i.cnt);
      cnt_nxt  = head_i.cnt;
      last_nxt = head_i.last;
    end

    out_valid      = valid_r;
    out_data_out   = data_r;
    out_byte_count = cnt_r;
    out_last       = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ks_r   <= ks_nxt;
    data_r <= data_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

endmodule

>>> hw/rtl/chacha20_keystream_xor_unit.sv
// An accepted request passes through the queue and then the output register; a request
// that opens a new block also waits in the queue while the generator runs its rounds.
// Throughput: one word per cycle within a block while out_ready is high, but the next
// block starts only with its first word and the four-entry queue fills meanwhile.
// Reset (rst_n low, synchronous): key, counter, nonce and word position go to zero and
// the request queue and the output register are emptied.
`include "chacha20_keystream_xor_unit_assert.svh"

module chacha20_keystream_xor_unit #(
  parameter int unsigned QUEUE_DEPTH = ccxor_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ccxor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccxor_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_msg_start,
  input  logic [31:0]                      in_seq_number,
  input  logic [31:0]                      in_start_block,
  input  logic [31:0]                      in_data_in,
  input  logic [ccxor_pkg::CNT_W-1:0]      in_byte_count,
  input  logic                             in_msg_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      out_data_out,
  output logic [ccxor_pkg::CNT_W-1:0]      out_byte_count,
  output logic                             out_last
);

  // The key is held here as eight 32-bit words. Each configuration request writes two
  // of them, low word first; an index beyond the last key register is dropped.
  ccxor_pkg::key_t      key_r, key_nxt;

  // Signals between the front end, the request queue, the generator and the back end.
  logic                 push;
  logic                 pop;
  logic                 take;
  logic                 q_full;
  logic                 q_valid;
  ccxor_pkg::q_entry_t  push_entry;
  ccxor_pkg::q_entry_t  head_entry;
  ccxor_pkg::gen_req_t  gen_req;
  ccxor_pkg::gen_stat_t gen_stat;
  ccxor_pkg::blk_t      gen_sum;

  assign cfg_ready = 1'b1;

  always_comb begin
    key_nxt = key_r;
    if (cfg_valid) begin
      case (cfg_index)
        ccxor_pkg::CFG_KEY_01: begin
          key_nxt[0] = cfg_data[31:0];
          key_nxt[1] = cfg_data[63:32];
        end
        ccxor_pkg::CFG_KEY_23: begin
          key_nxt[2] = cfg_data[31:0];
          key_nxt[3] = cfg_data[63:32];
        end
        ccxor_pkg::CFG_KEY_45: begin
          key_nxt[4] = cfg_data[31:0];
          key_nxt[5] = cfg_data[63:32];
        end
        ccxor_pkg::CFG_KEY_67: begin
          key_nxt[6] = cfg_data[31:0];
          key_nxt[7] = cfg_data[63:32];
        end
        default: begin
          key_nxt = key_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // The front end tracks the word position, block counter and nonce. It tags each
  // request that opens a block and starts the generator for it; such a request is accepted
  // only while the generator is idle, once the back end has taken the previous block.
  ccxor_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_msg_start   (in_msg_start),
    .in_seq_number  (in_seq_number),
    .in_start_block (in_start_block),
    .in_data_in     (in_data_in),
    .in_byte_count  (in_byte_count),
    .in_msg_last    (in_msg_last),
    .q_full_i       (q_full),
    .gen_stat_i     (gen_stat),
    .push_o         (push),
    .entry_o        (push_entry),
    .req_o          (gen_req)
  );

  // A short queue lets the front end run ahead while the output side is stalled.
  ccxor_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .head_o  (head_entry)
  );

  // The generator runs one round per cycle and holds its finished block until the
  // back end takes it, which is what lets it start the next one.
  ccxor_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .key_i  (key_r),
    .req_i  (gen_req),
    .take_i (take),
    .stat_o (gen_stat),
    .sum_o  (gen_sum)
  );

  // The back end keeps the current keystream block, XORs and masks each word and
  // drives the output register.
  ccxor_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid_i      (q_valid),
    .head_i         (head_entry),
    .pop_o          (pop),
    .gen_stat_i     (gen_stat),
    .gen_sum_i      (gen_sum),
    .take_o         (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_byte_count (out_byte_count),
    .out_last       (out_last)
  );

  // Only one block may be in flight in the generator at a time.
  `CCXOR_ASSERT_SAME(a_start_when_idle, gen_req.start, gen_stat.idle, "generator busy")
  // A request that opens a block may only leave the queue with a finished block.
  `CCXOR_ASSERT_SAME(a_take_when_done, pop && head_entry.new_blk, gen_stat.done, "early take")
  // The queue is never written when it is full, unless an entry leaves in the same cycle.
  `CCXOR_ASSERT_SAME(a_no_overflow, push, !q_full || pop, "request queue overflow")
  // A started generator leaves the idle state on the next cycle.
  `CCXOR_ASSERT_NEXT(a_start_runs, gen_req.start, !gen_stat.idle && !gen_stat.done, "no start")

endmodule
